/* rtl/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, request codes and controller/datapath signal groups for the
// periodic task timer bank.
// ----------------------------------------------------------------------------
package ptt_pkg;

   // default bank sizes
   localparam int NUM_TASKS_DEF = 16;
   localparam int LOW_TASKS_DEF = 1;

   // payload types
   typedef logic [1:0]         func_type;
   typedef logic [3:0]         index_type;
   typedef logic [15:0]        interval_type;
   typedef logic [15:0]        mask_type;
   typedef logic signed [16:0] count_type;

   // request function codes
   localparam func_type FUNC_TICK    = 2'd0;
   localparam func_type FUNC_SET     = 2'd1;
   localparam func_type FUNC_SERVICE = 2'd2;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic exec;
      logic sweep;
      logic load_rsp;
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic sweep_last;
      logic rsp_free;
   } dp_status_type;

endpackage

/* rtl/ptt_if.sv */
// ----------------------------------------------------------------------------
// ptt request and response channels
// Valid/ready channel interfaces with source and sink modports.
// ----------------------------------------------------------------------------
interface ptt_req_if;
   logic                   valid;
   logic                   ready;
   ptt_pkg::func_type      func;
   logic                   bank;
   ptt_pkg::index_type     task_index;
   logic                   enable_bit;
   ptt_pkg::interval_type  interval;
   logic                   run_pending;

   modport source (output valid, func, bank, task_index, enable_bit, interval,
                   run_pending, input ready);
   modport sink   (input valid, func, bank, task_index, enable_bit, interval,
                   run_pending, output ready);
endinterface

interface ptt_rsp_if;
   logic               valid;
   logic               ready;
   ptt_pkg::mask_type  pending_mask;
   ptt_pkg::mask_type  fired_mask;

   modport source (output valid, pending_mask, fired_mask, input ready);
   modport sink   (input valid, pending_mask, fired_mask, output ready);
endinterface

/* rtl/ptt_ctrl.sv */
// ----------------------------------------------------------------------------
// ptt_ctrl
// Controller: accepts one request, runs the set/service step or the tick
// sweep, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ptt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  ptt_pkg::func_type       req_func,
   output logic                    req_ready,
   input  ptt_pkg::dp_status_type  status,
   output ptt_pkg::ctrl_cmd_type   cmd
);

   ptt_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == ptt_pkg::FUNC_TICK) ? ptt_pkg::ST_SWEEP
                                                           : ptt_pkg::ST_EXEC;
            end
         end
         ptt_pkg::ST_EXEC: begin
            state_in = ptt_pkg::ST_FINISH;
         end
         ptt_pkg::ST_SWEEP: begin
            if (status.sweep_last) state_in = ptt_pkg::ST_FINISH;
         end
         ptt_pkg::ST_FINISH: begin
            if (status.rsp_free) state_in = ptt_pkg::ST_IDLE;
         end
         default: state_in = ptt_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ptt_pkg::ST_EXEC:   cmd.exec = 1'b1;
         ptt_pkg::ST_SWEEP:  cmd.sweep = 1'b1;
         ptt_pkg::ST_FINISH: cmd.load_rsp = status.rsp_free;
         default: ;
      endcase
   end

endmodule

/* rtl/ptt_datapath.sv */
// ----------------------------------------------------------------------------
// ptt_datapath
// Channel storage, shared countdown decrementer, request latch and output
// register of the periodic task timer bank.
// ----------------------------------------------------------------------------
module ptt_datapath #(
   parameter int NUM_TASKS = ptt_pkg::NUM_TASKS_DEF,
   parameter int LOW_TASKS = ptt_pkg::LOW_TASKS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ptt_pkg::ctrl_cmd_type   cmd,
   output ptt_pkg::dp_status_type  status,
   input  ptt_pkg::func_type       req_func,
   input  logic                    req_bank,
   input  ptt_pkg::index_type      req_task_index,
   input  logic                    req_enable_bit,
   input  ptt_pkg::interval_type   req_interval,
   input  logic                    req_run_pending,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output ptt_pkg::mask_type       rsp_pending_mask,
   output ptt_pkg::mask_type       rsp_fired_mask
);

   localparam int TOT = NUM_TASKS + LOW_TASKS;
   localparam int CW  = $clog2(TOT);

   localparam logic [TOT-1:0] HI_SEL  = TOT'((64'd1 << NUM_TASKS) - 64'd1);
   localparam logic [15:0]    HI_MASK = 16'((32'd1 << NUM_TASKS) - 32'd1);
   localparam logic [15:0]    LO_MASK = 16'((32'd1 << LOW_TASKS) - 32'd1);
   localparam logic [4:0]     HI_SIZE = 5'(NUM_TASKS);
   localparam logic [4:0]     LO_SIZE = 5'(LOW_TASKS);
   localparam logic [CW:0]    LO_BASE = (CW+1)'(NUM_TASKS);

   // pick one bank out of a per-channel vector, channel 0 of the bank at bit 0
   function automatic ptt_pkg::mask_type bank_view(input logic [TOT-1:0] vec,
                                                   input logic bank);
      logic [TOT+15:0] pad;
      pad = {16'd0, vec};
      if (bank) bank_view = pad[NUM_TASKS +: 16] & LO_MASK;
      else      bank_view = pad[15:0] & HI_MASK;
   endfunction

   // channel state
   ptt_pkg::interval_type  reload_ff [TOT];
   ptt_pkg::count_type     cd_ff [TOT];
   logic [TOT-1:0]         en_ff, en_in;
   logic [TOT-1:0]         pend_ff, pend_in;

   // latched request
   ptt_pkg::func_type      func_ff;
   logic                   bank_ff;
   ptt_pkg::index_type     idx_ff;
   logic                   enb_ff;
   ptt_pkg::interval_type  itv_ff;
   logic                   run_ff;

   // sweep and result
   logic [3:0]             pos_ff, pos_in;
   ptt_pkg::mask_type      fired_ff, fired_in;
   logic                   out_valid_ff, out_valid_in;
   ptt_pkg::mask_type      out_pend_ff, out_fired_ff;

   // channel write port
   logic                   wr_ena;
   ptt_pkg::count_type     cd_wr_in;
   ptt_pkg::interval_type  reload_wr_in;

   logic [4:0]             size_sel;
   logic [CW:0]            base_sel;
   logic [3:0]             offset;
   logic [CW:0]            chan_wide;
   logic [CW-1:0]          chan;
   logic                   in_range;
   ptt_pkg::count_type     cd_dec;
   logic                   expire;
   logic [TOT-1:0]         sel_vec;
   logic [TOT-1:0]         fire_vec;

   // channel addressing: request index for set and service, sweep position for a tick
   assign size_sel  = bank_ff ? LO_SIZE : HI_SIZE;
   assign base_sel  = bank_ff ? LO_BASE : '0;
   assign offset    = (func_ff == ptt_pkg::FUNC_TICK) ? pos_ff : idx_ff;
   assign chan_wide = base_sel + (CW+1)'(offset);
   assign chan      = chan_wide[CW-1:0];
   assign in_range  = ({1'b0, idx_ff} < size_sel);
   assign sel_vec   = bank_ff ? ~HI_SEL : HI_SEL;
   assign fire_vec  = en_ff & pend_ff & sel_vec;

   // shared decrementer
   assign cd_dec = cd_ff[chan] - 17'sd1;
   assign expire = (cd_dec <= 17'sd0);

   // next values
   always_comb begin
      en_in        = en_ff;
      pend_in      = pend_ff;
      fired_in     = fired_ff;
      pos_in       = pos_ff;
      wr_ena       = 1'b0;
      cd_wr_in     = cd_dec;
      reload_wr_in = reload_ff[chan];
      if (cmd.accept) begin
         fired_in = '0;
         pos_in   = '0;
      end
      if (cmd.exec) begin
         case (func_ff)
            ptt_pkg::FUNC_SET: begin
               if (in_range) begin
                  wr_ena        = 1'b1;
                  en_in[chan]   = enb_ff;
                  pend_in[chan] = run_ff;
                  cd_wr_in      = {1'b0, itv_ff};
                  reload_wr_in  = itv_ff;
               end
            end
            ptt_pkg::FUNC_SERVICE: begin
               pend_in  = pend_ff & ~fire_vec;
               fired_in = bank_view(fire_vec, bank_ff);
            end
            default: ;
         endcase
      end
      if (cmd.sweep) begin
         pos_in = pos_ff + 4'd1;
         if (en_ff[chan]) begin
            wr_ena = 1'b1;
            if (expire) begin
               cd_wr_in      = {1'b0, reload_ff[chan]};
               pend_in[chan] = 1'b1;
            end
         end
      end
   end

   // output register next value
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_rsp)  out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   // control and channel registers
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff        <= '0;
         pend_ff      <= '0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < TOT; i++) begin
            reload_ff[i] <= '0;
            cd_ff[i]     <= '0;
         end
      end else begin
         en_ff        <= en_in;
         pend_ff      <= pend_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
         if (wr_ena) begin
            reload_ff[chan] <= reload_wr_in;
            cd_ff[chan]     <= cd_wr_in;
         end
      end
   end

   // request latch and result payload
   always_ff @(posedge clock) begin
      fired_ff <= fired_in;
      if (cmd.accept) begin
         func_ff <= req_func;
         bank_ff <= req_bank;
         idx_ff  <= req_task_index;
         enb_ff  <= req_enable_bit;
         itv_ff  <= req_interval;
         run_ff  <= req_run_pending;
      end
      if (cmd.load_rsp) begin
         out_pend_ff  <= bank_view(pend_ff, bank_ff);
         out_fired_ff <= fired_ff;
      end
   end

   // status to controller
   assign status.sweep_last = ({1'b0, pos_ff} == (size_sel - 5'd1));
   assign status.rsp_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid        = out_valid_ff;
   assign rsp_pending_mask = out_pend_ff;
   assign rsp_fired_mask   = out_fired_ff;

endmodule

/* rtl/periodic_task_timer_bank.sv */
// ----------------------------------------------------------------------------
// periodic_task_timer_bank
// Two banks of periodic task timers driven by tick, set and service requests.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request: a tick for a bank, a set of one channel,
//   or a service of a bank's pending channels. rsp_chan returns one result
//   per request: the bank's pending mask after the step and the fired mask.
//   Requests are taken one at a time. A tick walks the bank's channels
//   through one shared decrementer, one channel per cycle; set and
//   service run the exec step on the latched request. The result enters
//   the output register once the sweep or step is done and the register
//   is free, and is shown the cycle after.
//   The output register decouples the sides: a waiting result does not stop
//   the next request from being taken and worked on; only its hand-off
//   waits until the receiver takes the earlier result.
//   Reset (synchronous) disables every channel, clears pending bits,
//   intervals and countdowns, and empties the output register.
// ----------------------------------------------------------------------------
module periodic_task_timer_bank #(
   parameter int NUM_TASKS = ptt_pkg::NUM_TASKS_DEF,
   parameter int LOW_TASKS = ptt_pkg::LOW_TASKS_DEF
) (
   input  logic   clock,
   input  logic   reset,
   ptt_req_if.sink   req_chan,
   ptt_rsp_if.source rsp_chan
);

   ptt_pkg::ctrl_cmd_type   cmd;
   ptt_pkg::dp_status_type  status;
   logic                    req_ready;

   // controller
   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   ptt_datapath #(
      .NUM_TASKS (NUM_TASKS),
      .LOW_TASKS (LOW_TASKS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (req_chan.func),
      .req_bank         (req_chan.bank),
      .req_task_index   (req_chan.task_index),
      .req_enable_bit   (req_chan.enable_bit),
      .req_interval     (req_chan.interval),
      .req_run_pending  (req_chan.run_pending),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_pending_mask (rsp_chan.pending_mask),
      .rsp_fired_mask   (rsp_chan.fired_mask)
   );

   assign req_chan.ready = req_ready;

endmodule

/* rtl/ptt_checker.sv */
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks of the periodic task timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module ptt_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input ptt_pkg::mask_type  pending_mask,
   input ptt_pkg::mask_type  fired_mask
);

   // output register is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pending_mask)
                                && $stable(fired_mask))
      else $error("stalled response changed");

   // one request at a time: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a serviced channel is no longer pending
   a_fired_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((fired_mask & pending_mask) == 16'd0))
      else $error("fired channel still pending");

endmodule

bind periodic_task_timer_bank ptt_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .pending_mask (rsp_chan.pending_mask),
   .fired_mask   (rsp_chan.fired_mask)
);
